FILE: rtl/cnef_pkg.sv
// ----------------------------------------------------------------------------
// cnef_pkg: shared types and functions of the CRC-8 framer and line encoder
// Holds the queue word format, the CRC-8 byte update and the nibble table.
// ----------------------------------------------------------------------------
package cnef_pkg;

	localparam logic [7:0] CRC_POLY        = 8'h97;
	localparam logic [7:0] START_DELIM_RST = 8'h02;
	localparam logic [7:0] END_DELIM_RST   = 8'h07;
	localparam logic [7:0] CODE_BIT3       = 8'h08;

	// Register indexes on the configuration port.
	localparam logic REG_START_DELIM = 1'b0;
	localparam logic REG_END_DELIM   = 1'b1;

	localparam logic [7:0] NIBBLE_CODE [8] = '{
		8'hA0, 8'h90, 8'hE0, 8'hD0, 8'hB0, 8'h80, 8'hF0, 8'hC0
	};

	// One accepted word, classified and with its delimiters captured.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       first_byte;
		logic [7:0] start_delim;
		logic [7:0] end_delim;
	} entry_t;

	// Eight steps of the MSB-first CRC on one byte.
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] code_of(input logic [3:0] nib);
		return NIBBLE_CODE[nib[2:0]] | (nib[3] ? CODE_BIT3 : 8'h00);
	endfunction

endpackage

FILE: rtl/cnef_ifs.sv
// ----------------------------------------------------------------------------
// cnef_ifs: stream channels of the framer
// Input channel carries payload bytes, output channel carries code bytes.
// ----------------------------------------------------------------------------
interface cnef_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cnef_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       run_last;
	logic       frame_last;

	modport source (output valid, output code_byte, output run_last, output frame_last,
		input ready);
	modport sink   (input valid, input code_byte, input run_last, input frame_last,
		output ready);
endinterface

FILE: rtl/cnef_regs.sv
// ----------------------------------------------------------------------------
// cnef_regs: configuration registers
// APB-style write and read of the start and end delimiters.
// ----------------------------------------------------------------------------
module cnef_regs
	import cnef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  start_delim,
	output logic [7:0]  end_delim
);

	logic [7:0] start_delim_q;
	logic [7:0] end_delim_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delim_q <= START_DELIM_RST;
			end_delim_q   <= END_DELIM_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_START_DELIM: start_delim_q <= pwdata[7:0];
				REG_END_DELIM:   end_delim_q   <= pwdata[7:0];
				default:         start_delim_q <= start_delim_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START_DELIM: prdata = {24'h0, start_delim_q};
			REG_END_DELIM:   prdata = {24'h0, end_delim_q};
			default:         prdata = 32'h0;
		endcase
	end

	assign start_delim = start_delim_q;
	assign end_delim   = end_delim_q;

endmodule

FILE: rtl/cnef_front.sv
// ----------------------------------------------------------------------------
// cnef_front: input acceptance and classification
// Marks the first word of a frame and captures the delimiters in use.
// ----------------------------------------------------------------------------
module cnef_front
	import cnef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cnef_in_if.sink     data,
	input  logic [7:0]  start_delim,
	input  logic [7:0]  end_delim,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);

	logic in_frame_q;

	assign data.ready = !q_full;
	assign push       = data.valid && !q_full;

	assign push_entry.data_byte   = data.data_byte;
	assign push_entry.last_byte   = data.last_byte;
	assign push_entry.first_byte  = !in_frame_q;
	assign push_entry.start_delim = start_delim;
	assign push_entry.end_delim   = end_delim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= !data.last_byte;
		end
	end

endmodule

FILE: rtl/cnef_queue.sv
// ----------------------------------------------------------------------------
// cnef_queue: two-entry queue between front and back
// Lets the front keep accepting while the back drains a frame byte.
// ----------------------------------------------------------------------------
module cnef_queue
	import cnef_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   nonempty,
	output logic   full
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign nonempty = count_q != 2'd0;
	assign full     = count_q == 2'd2;
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/cnef_back.sv
// ----------------------------------------------------------------------------
// cnef_back: frame sequencer and line encoder
// Walks each queued word through its frame bytes, two code words per byte,
// and keeps the running CRC of the frame.
// ----------------------------------------------------------------------------
module cnef_back
	import cnef_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  head,
	input  logic    nonempty,
	output logic    pop,
	cnef_out_if.source code
);

	typedef enum logic [1:0] {K_START, K_DATA, K_END, K_CRC} kind_t;

	entry_t     cur_q;
	kind_t      kind_q;
	logic       phase_q;
	logic       busy_q;
	logic [7:0] crc_q;
	logic       ovalid_q;
	logic [7:0] code_byte_q;
	logic       run_last_q;
	logic       frame_last_q;

	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic       emit;
	logic       done;

	always_comb begin
		case (kind_q)
			K_START: cur_byte = cur_q.start_delim;
			K_DATA:  cur_byte = cur_q.data_byte;
			K_END:   cur_byte = cur_q.end_delim;
			K_CRC:   cur_byte = crc_q;
			default: cur_byte = cur_q.data_byte;
		endcase
	end

	assign nib  = phase_q ? cur_byte[3:0] : cur_byte[7:4];
	assign emit = busy_q && (!ovalid_q || code.ready);
	assign done = phase_q && (kind_q == K_CRC || (kind_q == K_DATA && !cur_q.last_byte));
	// The next word is loaded as the current one hands over its final code.
	assign pop  = nonempty && (!busy_q || (emit && done));

	assign code.valid      = ovalid_q;
	assign code.code_byte  = code_byte_q;
	assign code.run_last   = run_last_q;
	assign code.frame_last = frame_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			code_byte_q  <= code_of(nib);
			run_last_q   <= done;
			frame_last_q <= phase_q && kind_q == K_CRC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= K_START;
			phase_q  <= 1'b0;
			busy_q   <= 1'b0;
			crc_q    <= 8'h00;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (code.ready) begin
				ovalid_q <= 1'b0;
			end

			if (emit) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (kind_q == K_CRC) begin
						crc_q <= 8'h00;
					end else begin
						crc_q <= crc_feed(crc_q, cur_byte);
					end
					case (kind_q)
						K_START: kind_q <= K_DATA;
						K_DATA:  begin
							if (cur_q.last_byte) begin
								kind_q <= K_END;
							end else begin
								busy_q <= 1'b0;
							end
						end
						K_END:   kind_q <= K_CRC;
						K_CRC:   busy_q <= 1'b0;
						default: busy_q <= 1'b0;
					endcase
				end
			end

			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				kind_q  <= head.first_byte ? K_START : K_DATA;
			end
		end
	end

endmodule

FILE: rtl/crc8_framer_nibble_encoder_top.sv
// ----------------------------------------------------------------------------
// crc8_framer_nibble_encoder_top: CRC-8 framer with nibble line code
// Payload words enter on the data channel, each a byte with a last flag.
// Every frame byte (start delimiter, payload, end delimiter, CRC-8 with
// polynomial 0x97) leaves as two code words on the code channel, high nibble
// first. run_last marks the final code word caused by an input word and
// frame_last marks the CRC low nibble that closes the frame.
// The delimiters are set over the APB port at byte addresses 0 and 4.
// The code channel moves one word per cycle while the receiver takes each
// word. A middle payload byte gives two code words, the first byte of a frame
// four, the last six and a one-byte frame eight.
// A two-entry queue sits between the input side and the encoder, so input
// words keep being taken while code words wait on a stalled receiver; when
// it is full, data.ready drops. The output register holds its word until
// taken. Reset empties the queue, closes any open frame, clears the CRC and
// sets the delimiters to 0x02 and 0x07.
// ----------------------------------------------------------------------------
module crc8_framer_nibble_encoder_top
	import cnef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cnef_in_if.sink     data,
	cnef_out_if.source  code
);

	logic [7:0] start_delim;
	logic [7:0] end_delim;
	logic       push;
	entry_t     push_entry;
	logic       pop;
	entry_t     head;
	logic       nonempty;
	logic       q_full;

	cnef_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start_delim (start_delim),
		.end_delim   (end_delim)
	);

	cnef_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data        (data),
		.start_delim (start_delim),
		.end_delim   (end_delim),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	cnef_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty),
		.full       (q_full)
	);

	cnef_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.code     (code)
	);

endmodule
